### rtl/prt_pkg.sv
package prt_pkg;

    localparam int SLOT_COUNT_DEF = 16;

    localparam int MAC_W    = 48;
    localparam int TIME_W   = 32;
    localparam int RANGE_W  = 20;
    localparam int PERIOD_W = 16;
    localparam int FAIL_W   = 8;
    localparam int REQ_W    = 3;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 48;
    // period times the backoff factor of five
    localparam int BPERIOD_W = PERIOD_W + 3;

    localparam logic [REQ_W-1:0] REQ_SUCCESS = 3'd0;
    localparam logic [REQ_W-1:0] REQ_FAILURE = 3'd1;
    localparam logic [REQ_W-1:0] REQ_FRESH   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_LAST    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_DUE     = 3'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_SELF_MAC     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANGE_PERIOD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FAILURES = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_AGE      = 2'd3;

    localparam logic [MAC_W-1:0]    SELF_MAC_RST     = '0;
    localparam logic [PERIOD_W-1:0] RANGE_PERIOD_RST = 16'd200;
    localparam logic [FAIL_W-1:0]   MAX_FAILURES_RST = 8'd3;
    localparam logic [PERIOD_W-1:0] MAX_AGE_RST      = 16'd1000;

    localparam logic [RANGE_W-1:0] RANGE_SAT = 20'd1000000;
    localparam logic [FAIL_W-1:0]  FAIL_SAT  = 8'd255;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [MAC_W-1:0]   peer_mac;
        logic [TIME_W-1:0]  now_ms;
        logic [RANGE_W-1:0] range_mm;
    } t_req;

    typedef struct packed {
        logic               found;
        logic [RANGE_W-1:0] range_out_mm;
        logic [TIME_W-1:0]  measured_at_ms;
        logic               due;
    } t_res;

    typedef struct packed {
        logic [MAC_W-1:0]   mac;
        logic [RANGE_W-1:0] rng_mm;
        logic [TIME_W-1:0]  last_ok;
        logic [TIME_W-1:0]  last_attempt;
        logic [FAIL_W-1:0]  fail_count;
        logic               has_range;
    } t_entry;

endpackage

### rtl/prt_ram.sv
module prt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/peer_range_table.sv
// Peer range table: SLOT_COUNT entries of ranging results keyed by peer MAC.
//
// Input channel (i_in_valid / o_in_stall, payload i_in) carries one request;
// output channel (o_out_valid / i_out_stall, payload o_out) returns exactly
// one result transaction per request, in order.
// Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data);
// the user must write it only while the block is idle; nothing enforces that.
//
// Each request scans every slot of the entry RAM once (one read per cycle),
// then reads the chosen slot again and, for success, failure and due
// requests that act on it, writes it back. One request is worked on at a
// time and the block passes through idle before the next is taken.
// The input is not stalled while a finished result waits in the output
// register; a stalled receiver holds back the next result, and the input
// stays stalled until that result can be loaded.
// Reset clears the used marks of all slots (no clearing pass needed) and
// loads the register defaults; RAM contents count only in slots marked used.
module peer_range_table #(
    parameter int SLOT_COUNT = prt_pkg::SLOT_COUNT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  prt_pkg::t_req                   i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output prt_pkg::t_res                   o_out,
    input  logic                            i_cfg_we,
    input  logic [prt_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [prt_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    import prt_pkg::*;

    localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);
    localparam int EW = $bits(t_entry);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_DRAIN  = 3'd2;
    localparam logic [2:0] ST_DECIDE = 3'd3;
    localparam logic [2:0] ST_UPD    = 3'd4;
    localparam logic [2:0] ST_OUT    = 3'd5;

    logic [2:0]          r_state, n_state;
    logic [MAC_W-1:0]    r_self_mac;
    logic [PERIOD_W-1:0] r_period;
    logic [FAIL_W-1:0]   r_max_fail;
    logic [PERIOD_W-1:0] r_max_age;
    logic [SLOT_COUNT-1:0] r_used;

    t_req                r_req;
    logic [IW-1:0]       r_addr;
    logic                r_rd_vld;
    logic [IW-1:0]       r_rd_idx;

    logic                r_hit, r_rhit, r_free;
    logic [IW-1:0]       r_hit_idx, r_rhit_idx, r_free_idx, r_old_idx;
    logic [TIME_W-1:0]   r_old_age;

    logic [IW-1:0]       r_tgt;
    logic                r_new;
    logic                r_act;
    t_res                r_res;
    logic                r_out_vld;
    t_res                r_out;

    logic                w_accept;
    logic [IW-1:0]       w_raddr;
    logic [EW-1:0]       w_rdata;
    t_entry              w_rd;
    logic                w_rd_used;
    logic [TIME_W-1:0]   w_age;
    logic [IW-1:0]       w_tgt;
    logic                w_new;
    logic                w_act;
    t_entry              w_base;
    t_entry              w_wr;
    logic                w_we;
    t_res                w_res;
    logic [BPERIOD_W-1:0] w_bperiod;
    logic                w_load_out;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != ST_IDLE);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_self_mac <= SELF_MAC_RST;
            r_period   <= RANGE_PERIOD_RST;
            r_max_fail <= MAX_FAILURES_RST;
            r_max_age  <= MAX_AGE_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SELF_MAC:     r_self_mac <= i_cfg_data[MAC_W-1:0];
                CFG_RANGE_PERIOD: r_period   <= i_cfg_data[PERIOD_W-1:0];
                CFG_MAX_FAILURES: r_max_fail <= i_cfg_data[FAIL_W-1:0];
                CFG_MAX_AGE:      r_max_age  <= i_cfg_data[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    prt_ram #(
        .WIDTH (EW),
        .DEPTH (SLOT_COUNT),
        .AW    (IW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_tgt),
        .i_wdata (w_wr),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rd      = t_entry'(w_rdata);
    assign w_rd_used = r_used[r_rd_idx];
    assign w_age     = r_req.now_ms - w_rd.last_ok;

    // slot choice after the scan
    always_comb begin
        w_tgt = r_hit_idx;
        w_new = 1'b0;
        w_act = 1'b0;
        unique case (r_req.req_type)
            REQ_SUCCESS, REQ_FAILURE, REQ_DUE: begin
                w_act = (r_req.req_type != REQ_DUE) || (r_self_mac < r_req.peer_mac);
                w_new = !r_hit;
                priority if (r_hit) begin
                    w_tgt = r_hit_idx;
                end else if (r_free) begin
                    w_tgt = r_free_idx;
                end else begin
                    w_tgt = r_old_idx;
                end
            end
            REQ_FRESH, REQ_LAST: begin
                w_act = r_rhit;
                w_tgt = r_rhit_idx;
            end
            default: ;
        endcase
    end

    assign w_raddr = (r_state == ST_SCAN) ? r_addr : w_tgt;

    // read-modify-write of the chosen slot
    always_comb begin
        if (r_new) begin
            w_base = '0;
            w_base.mac = r_req.peer_mac;
        end else begin
            w_base = w_rd;
        end
        w_wr      = w_base;
        w_res     = '0;
        w_we      = 1'b0;
        w_bperiod = {3'b000, r_period};
        if (w_base.fail_count >= r_max_fail) begin
            w_bperiod = {1'b0, r_period, 2'b00} + {3'b000, r_period};
        end
        if (r_state == ST_UPD && r_act) begin
            unique case (r_req.req_type)
                REQ_SUCCESS: begin
                    w_we              = 1'b1;
                    w_wr.rng_mm       = (r_req.range_mm > RANGE_SAT) ? RANGE_SAT
                                                                     : r_req.range_mm;
                    w_wr.last_ok      = r_req.now_ms;
                    w_wr.last_attempt = r_req.now_ms;
                    w_wr.fail_count   = '0;
                    w_wr.has_range    = 1'b1;
                end
                REQ_FAILURE: begin
                    w_we              = 1'b1;
                    w_wr.last_attempt = r_req.now_ms;
                    if (w_base.fail_count != FAIL_SAT) begin
                        w_wr.fail_count = w_base.fail_count + 1'b1;
                    end
                end
                REQ_DUE: begin
                    w_we      = 1'b1;
                    w_res.due = ((r_req.now_ms - w_base.last_attempt)
                                 >= TIME_W'(w_bperiod));
                end
                REQ_FRESH: begin
                    if ((r_req.now_ms - w_base.last_ok) <= TIME_W'(r_max_age)) begin
                        w_res.found        = 1'b1;
                        w_res.range_out_mm = w_base.rng_mm;
                    end
                end
                REQ_LAST: begin
                    w_res.found          = 1'b1;
                    w_res.range_out_mm   = w_base.rng_mm;
                    w_res.measured_at_ms = w_base.last_ok;
                end
                default: ;
            endcase
        end
    end

    assign w_load_out = (r_state == ST_OUT) && (!r_out_vld || !i_out_stall);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (w_accept) n_state = ST_SCAN;
            ST_SCAN:   if (r_addr == LAST_IDX) n_state = ST_DRAIN;
            ST_DRAIN:  n_state = ST_DECIDE;
            ST_DECIDE: n_state = ST_UPD;
            ST_UPD:    n_state = ST_OUT;
            ST_OUT:    if (w_load_out) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_used    <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == ST_SCAN);
            if (w_we) begin
                r_used[r_tgt] <= 1'b1;
            end
            if (w_load_out) begin
                r_out_vld <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // scan bookkeeping and payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req     <= i_in;
            r_addr    <= '0;
            r_hit     <= 1'b0;
            r_rhit    <= 1'b0;
            r_free    <= 1'b0;
            r_hit_idx <= '0;
            r_rhit_idx <= '0;
            r_free_idx <= '0;
            r_old_idx <= '0;
            r_old_age <= '0;
        end else begin
            if (r_state == ST_SCAN && r_addr != LAST_IDX) begin
                r_addr <= r_addr + 1'b1;
            end
            if (r_rd_vld) begin
                if (!w_rd_used) begin
                    if (!r_free) begin
                        r_free     <= 1'b1;
                        r_free_idx <= r_rd_idx;
                    end
                end else begin
                    if (!r_hit && w_rd.mac == r_req.peer_mac) begin
                        r_hit     <= 1'b1;
                        r_hit_idx <= r_rd_idx;
                    end
                    if (!r_rhit && w_rd.has_range && w_rd.mac == r_req.peer_mac) begin
                        r_rhit     <= 1'b1;
                        r_rhit_idx <= r_rd_idx;
                    end
                    // ties go to the later slot
                    if (w_age >= r_old_age) begin
                        r_old_age <= w_age;
                        r_old_idx <= r_rd_idx;
                    end
                end
            end
        end
        r_rd_idx <= r_addr;
        if (r_state == ST_DECIDE) begin
            r_tgt <= w_tgt;
            r_new <= w_new;
            r_act <= w_act;
        end
        if (r_state == ST_UPD) begin
            r_res <= w_res;
        end
        if (w_load_out) begin
            r_out <= r_res;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

    a_out_from_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state) == ST_OUT)
        else $error("result appeared outside the output step");

    a_scan_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SCAN && r_addr != LAST_IDX) |=> r_addr == $past(r_addr) + 1'b1)
        else $error("scan address did not advance");

    a_used_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |=> r_used[$past(r_tgt)])
        else $error("written slot not marked used");

    a_found_due_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out.found && o_out.due))
        else $error("found and due both set");

endmodule

### test/peer_range_table_test.sv
module peer_range_table_test;
    timeunit 1ns;
    timeprecision 1ps;

    import prt_pkg::*;

    localparam int SLOTS = SLOT_COUNT_DEF;
    localparam int POOL_SIZE = 20;
    localparam int LONG_HOLD = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PRINT_LIMIT = 40;
    localparam int BACKOFF = 5;
    // request codes the block must ignore
    localparam logic [REQ_W-1:0] REQ_UNUSED_FIRST = 3'd5;
    localparam logic [REQ_W-1:0] REQ_UNUSED_LAST = 3'd7;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_req i_in = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    t_res o_out;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    peer_range_table #(.SLOT_COUNT(SLOTS)) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid),
        .o_in_stall(o_in_stall),
        .i_in(i_in),
        .o_out_valid(o_out_valid),
        .i_out_stall(i_out_stall),
        .o_out(o_out),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_data(i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    // shadow copy of the table and its registers
    logic [MAC_W-1:0] cfg_self_mac = SELF_MAC_RST;
    logic [PERIOD_W-1:0] cfg_period = RANGE_PERIOD_RST;
    logic [FAIL_W-1:0] cfg_max_fail = MAX_FAILURES_RST;
    logic [PERIOD_W-1:0] cfg_max_age = MAX_AGE_RST;

    logic [MAC_W-1:0] slot_mac [SLOTS];
    logic [RANGE_W-1:0] slot_range [SLOTS];
    logic [TIME_W-1:0] slot_last_ok [SLOTS];
    logic [TIME_W-1:0] slot_last_try [SLOTS];
    logic [FAIL_W-1:0] slot_fails [SLOTS];
    bit slot_ranged [SLOTS];
    bit slot_used [SLOTS] = '{default: 1'b0};

    t_res answers_due[$];
    logic [MAC_W-1:0] peer_pool [POOL_SIZE];
    logic [TIME_W-1:0] now_cursor = '0;

    bit idling_on = 1'b1;
    bit long_hold_pending = 1'b0;
    int out_stall_left = 0;
    int quiet_cycles = 0;
    int error_count = 0;
    int requests_sent = 0;
    int results_checked = 0;
    int setting_changes = 0;
    int long_holds = 0;
    int sent_by_type [8] = '{default: 0};

    function automatic int match_slot(logic [MAC_W-1:0] mac, bit need_range);
        for (int i = 0; i < SLOTS; i++)
            if (slot_used[i] && (slot_ranged[i] || !need_range) && slot_mac[i] == mac)
                return i;
        return -1;
    endfunction

    // existing entry, else first free slot, else the one longest without a success
    function automatic int claim_slot(logic [MAC_W-1:0] mac, logic [TIME_W-1:0] now);
        int target;
        logic [TIME_W-1:0] age;
        logic [TIME_W-1:0] oldest_age;
        target = match_slot(mac, 1'b0);
        if (target >= 0)
            return target;
        for (int i = 0; i < SLOTS; i++) begin
            if (!slot_used[i]) begin
                target = i;
                break;
            end
        end
        if (target < 0) begin
            target = 0;
            oldest_age = '0;
            for (int i = 0; i < SLOTS; i++) begin
                age = now - slot_last_ok[i];
                if (age >= oldest_age) begin
                    oldest_age = age;
                    target = i;
                end
            end
        end
        slot_mac[target] = mac;
        slot_range[target] = '0;
        slot_last_ok[target] = '0;
        slot_last_try[target] = '0;
        slot_fails[target] = '0;
        slot_ranged[target] = 1'b0;
        slot_used[target] = 1'b1;
        return target;
    endfunction

    function automatic t_res table_answer(t_req req);
        t_res res;
        int s;
        logic [BPERIOD_W-1:0] period;
        logic [TIME_W-1:0] age;
        res = '0;
        case (req.req_type)
            REQ_SUCCESS: begin
                s = claim_slot(req.peer_mac, req.now_ms);
                slot_range[s] = (req.range_mm > RANGE_SAT) ? RANGE_SAT : req.range_mm;
                slot_last_ok[s] = req.now_ms;
                slot_last_try[s] = req.now_ms;
                slot_fails[s] = '0;
                slot_ranged[s] = 1'b1;
            end
            REQ_FAILURE: begin
                s = claim_slot(req.peer_mac, req.now_ms);
                slot_last_try[s] = req.now_ms;
                if (slot_fails[s] != FAIL_SAT)
                    slot_fails[s] = slot_fails[s] + 1'b1;
            end
            REQ_FRESH: begin
                s = match_slot(req.peer_mac, 1'b1);
                if (s >= 0) begin
                    age = req.now_ms - slot_last_ok[s];
                    if (age <= cfg_max_age) begin
                        res.found = 1'b1;
                        res.range_out_mm = slot_range[s];
                    end
                end
            end
            REQ_LAST: begin
                s = match_slot(req.peer_mac, 1'b1);
                if (s >= 0) begin
                    res.found = 1'b1;
                    res.range_out_mm = slot_range[s];
                    res.measured_at_ms = slot_last_ok[s];
                end
            end
            REQ_DUE: begin
                if (cfg_self_mac < req.peer_mac) begin
                    s = claim_slot(req.peer_mac, req.now_ms);
                    period = BPERIOD_W'(cfg_period);
                    if (slot_fails[s] >= cfg_max_fail)
                        period = BPERIOD_W'(period * BACKOFF);
                    age = req.now_ms - slot_last_try[s];
                    res.due = (age >= period);
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    function automatic t_req request_of(logic [REQ_W-1:0] kind, logic [MAC_W-1:0] mac,
                                        logic [TIME_W-1:0] now, logic [RANGE_W-1:0] mm);
        t_req req;
        req.req_type = kind;
        req.peer_mac = mac;
        req.now_ms = now;
        req.range_mm = mm;
        return req;
    endfunction

    function automatic t_req random_request();
        t_req req;
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 25) req.req_type = REQ_SUCCESS;
        else if (pick < 45) req.req_type = REQ_FAILURE;
        else if (pick < 65) req.req_type = REQ_FRESH;
        else if (pick < 80) req.req_type = REQ_LAST;
        else if (pick < 95) req.req_type = REQ_DUE;
        else req.req_type = REQ_W'($urandom_range(REQ_UNUSED_FIRST, REQ_UNUSED_LAST));
        pick = $urandom_range(0, 19);
        if (pick == 0) req.peer_mac = {16'($urandom), $urandom};
        else if (pick == 1) req.peer_mac = cfg_self_mac;
        else if (pick == 2) req.peer_mac = cfg_self_mac + 1'b1;
        else req.peer_mac = peer_pool[$urandom_range(0, POOL_SIZE - 1)];
        // mostly small time steps so freshness and due checks land on both sides
        pick = $urandom_range(0, 19);
        if (pick == 0) now_cursor = $urandom;
        else if (pick < 3) now_cursor += $urandom_range(0, 400000);
        else now_cursor += $urandom_range(0, 60);
        req.now_ms = now_cursor;
        pick = $urandom_range(0, 9);
        if (pick == 0) req.range_mm = RANGE_W'($urandom_range(RANGE_SAT, {RANGE_W{1'b1}}));
        else if (pick == 1) req.range_mm = 20'($urandom);
        else req.range_mm = RANGE_W'($urandom_range(0, RANGE_SAT));
        return req;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        error_count++;
        if (error_count <= PRINT_LIMIT)
            $display("%0t: %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    task automatic send_request(t_req req);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        i_in <= req;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        answers_due.push_back(table_answer(req));
        requests_sent++;
        sent_by_type[req.req_type]++;
    endtask

    task automatic settle_table();
        i_in_valid <= 1'b0;
        while (answers_due.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_settings(logic [MAC_W-1:0] mac, logic [PERIOD_W-1:0] period,
                                  logic [FAIL_W-1:0] max_fail, logic [PERIOD_W-1:0] max_age);
        settle_table();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_SELF_MAC;
        i_cfg_data <= mac;
        @(posedge i_clk);
        i_cfg_idx <= CFG_RANGE_PERIOD;
        i_cfg_data <= CFG_DATA_W'(period);
        @(posedge i_clk);
        i_cfg_idx <= CFG_MAX_FAILURES;
        i_cfg_data <= CFG_DATA_W'(max_fail);
        @(posedge i_clk);
        i_cfg_idx <= CFG_MAX_AGE;
        i_cfg_data <= CFG_DATA_W'(max_age);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_self_mac = mac;
        cfg_period = period;
        cfg_max_fail = max_fail;
        cfg_max_age = max_age;
        setting_changes++;
    endtask

    // register defaults straight out of reset, nothing stored yet
    task automatic test_empty_table();
        send_request(request_of(REQ_FRESH, 48'h1, 32'd0, '0));
        send_request(request_of(REQ_LAST, 48'h1, 32'd0, '0));
        send_request(request_of(REQ_DUE, 48'h0, 32'd500, '0));   // equal MAC, not initiator
        send_request(request_of(REQ_DUE, 48'h1, 32'd199, '0));   // allocates, not yet due
        send_request(request_of(REQ_DUE, 48'h1, 32'd200, '0));
        send_request(request_of(REQ_FRESH, 48'h1, 32'd200, '0)); // entry without a range
        send_request(request_of(REQ_UNUSED_FIRST, {MAC_W{1'b1}}, '1, '1));
        send_request(request_of(REQ_UNUSED_LAST, 48'h1, 32'd300, 20'd5));
        send_request(request_of(REQ_LAST, 48'h1, 32'd300, '0));
    endtask

    task automatic test_record_and_query();
        write_settings(48'h8000_0000_0000, 16'd100, 8'd2, 16'd500);
        send_request(request_of(REQ_SUCCESS, {MAC_W{1'b1}}, 32'hFFFF_FF00, {RANGE_W{1'b1}}));
        send_request(request_of(REQ_FRESH, {MAC_W{1'b1}}, 32'h0000_00F4, '0)); // age at limit
        send_request(request_of(REQ_FRESH, {MAC_W{1'b1}}, 32'h0000_00F5, '0)); // one past it
        send_request(request_of(REQ_LAST, {MAC_W{1'b1}}, 32'h0000_00F5, '0));
        send_request(request_of(REQ_SUCCESS, 48'h0, 32'd5, 20'd0));
        send_request(request_of(REQ_LAST, 48'h0, 32'd9, '0));
        send_request(request_of(REQ_FRESH, 48'h0, 32'd5, '0));
        send_request(request_of(REQ_SUCCESS, {MAC_W{1'b1}}, 32'd10, RANGE_SAT));
        send_request(request_of(REQ_FAILURE, {MAC_W{1'b1}}, 32'd20, '0));
        send_request(request_of(REQ_LAST, {MAC_W{1'b1}}, 32'd30, '0));
        send_request(request_of(REQ_SUCCESS, 48'h8000_0000_0001, '1, RANGE_SAT - 1'b1));
        send_request(request_of(REQ_FRESH, 48'h8000_0000_0001, 32'd0, '0));
    endtask

    task automatic test_due_and_backoff();
        write_settings(48'h10, 16'd300, 8'd2, 16'd1000);
        send_request(request_of(REQ_DUE, 48'h20, 32'd1000, '0));
        send_request(request_of(REQ_FAILURE, 48'h20, 32'd1000, '0));
        send_request(request_of(REQ_DUE, 48'h20, 32'd1299, '0));
        send_request(request_of(REQ_DUE, 48'h20, 32'd1300, '0));
        send_request(request_of(REQ_FAILURE, 48'h20, 32'd1300, '0)); // period now five times
        send_request(request_of(REQ_DUE, 48'h20, 32'd2799, '0));
        send_request(request_of(REQ_DUE, 48'h20, 32'd2800, '0));
        send_request(request_of(REQ_SUCCESS, 48'h20, 32'd2800, 20'd1234));
        send_request(request_of(REQ_DUE, 48'h20, 32'd3100, '0));
        send_request(request_of(REQ_DUE, 48'h10, 32'd3100, '0));
        send_request(request_of(REQ_DUE, 48'h0F, 32'd3100, '0));
        send_request(request_of(REQ_DUE, 48'h21, 32'd0, '0));
    endtask

    // more peers than slots: the stalest success is evicted, ties to the highest index
    task automatic test_slot_eviction();
        logic [MAC_W-1:0] peers [20];
        logic [TIME_W-1:0] base;
        write_settings(48'h0, 16'd50, 8'd4, 16'd2000);
        base = $urandom;
        for (int i = 0; i < 20; i++)
            peers[i] = {16'($urandom), $urandom} | 48'h1;
        for (int i = 0; i < 17; i++)
            send_request(request_of(REQ_FAILURE, peers[i], base, '0));
        for (int i = 0; i < 8; i++)
            send_request(request_of(REQ_SUCCESS, peers[i], base + 16 + i, 20'($urandom)));
        for (int i = 16; i < 20; i++)
            send_request(request_of(REQ_SUCCESS, peers[i], base + 3000, 20'($urandom)));
        for (int i = 0; i < 20; i++)
            send_request(request_of((i % 2) ? REQ_FRESH : REQ_LAST, peers[i], base + 3100, '0));
    endtask

    task automatic test_fail_saturation();
        logic [MAC_W-1:0] mac;
        write_settings(48'h0, 16'd1000, FAIL_SAT, 16'($urandom));
        mac = {16'($urandom), $urandom} | 48'h1;
        now_cursor = $urandom;
        for (int n = 0; n < 262; n++) begin
            now_cursor += $urandom_range(0, 40);
            send_request(request_of(REQ_FAILURE, mac, now_cursor, 20'($urandom)));
            if (n % 16 == 15 || n >= 252)
                send_request(request_of(REQ_DUE, mac, now_cursor + $urandom_range(900, 5100), '0));
        end
        send_request(request_of(REQ_LAST, mac, now_cursor, '0));
        send_request(request_of(REQ_SUCCESS, mac, now_cursor, 20'($urandom)));
        send_request(request_of(REQ_DUE, mac, now_cursor + $urandom_range(900, 1100), '0));
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: write_settings({16'($urandom), $urandom}, 16'($urandom_range(0, 2000)),
                                  8'($urandom_range(0, 8)), 16'($urandom_range(0, 3000)));
                1: write_settings('0, '0, '0, '0);
                2: write_settings('1, '1, '1, '1);
                default: write_settings({16'($urandom), $urandom}, '1, 8'd1, 16'($urandom));
            endcase
            idling_on = (phase != 1);
            peer_pool[0] = '0;
            peer_pool[1] = '1;
            for (int i = 2; i < POOL_SIZE; i++)
                peer_pool[i] = {16'($urandom), $urandom};
            now_cursor = $urandom;
            repeat (180) send_request(random_request());
        end
        idling_on = 1'b1;
    endtask

    // receiver holds off long enough that the input must stall
    task automatic test_output_backpressure();
        settle_table();
        idling_on = 1'b0;
        long_hold_pending = 1'b1;
        repeat (40) send_request(random_request());
    endtask

    task automatic test_quiet_tail();
        write_settings({16'($urandom), $urandom}, 16'($urandom_range(0, 300)), 8'd3, 16'd500);
        idling_on = 1'b0;
        repeat (150) send_request(random_request());
    endtask

    always @(posedge i_clk) begin
        if (out_stall_left != 0) begin
            out_stall_left--;
        end else if (long_hold_pending) begin
            long_hold_pending = 1'b0;
            long_holds++;
            out_stall_left = LONG_HOLD - 1;
            i_out_stall <= 1'b1;
        end else if (idling_on && $urandom_range(0, 5) == 0) begin
            out_stall_left = $urandom_range(1, 12) - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : check_answers
        t_res want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (answers_due.size() == 0) begin
                report_mismatch("result with no request pending", 64'(o_out), '0);
            end else begin
                want = answers_due.pop_front();
                results_checked++;
                if (o_out.found !== want.found)
                    report_mismatch("found", 64'(o_out.found), 64'(want.found));
                if (o_out.range_out_mm !== want.range_out_mm)
                    report_mismatch("range_out_mm", 64'(o_out.range_out_mm),
                                    64'(want.range_out_mm));
                if (o_out.measured_at_ms !== want.measured_at_ms)
                    report_mismatch("measured_at_ms", 64'(o_out.measured_at_ms),
                                    64'(want.measured_at_ms));
                if (o_out.due !== want.due)
                    report_mismatch("due", 64'(o_out.due), 64'(want.due));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("no transaction for %0d cycles, %0d results outstanding",
                     quiet_cycles, answers_due.size());
            $display("peer_range_table_test: done, errors");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_table();
        test_record_and_query();
        test_due_and_backoff();
        test_slot_eviction();
        test_fail_saturation();
        test_random_traffic();
        test_output_backpressure();
        test_quiet_tail();
        settle_table();
        repeat (SLOTS + 9) @(posedge i_clk);
        $display("%0d requests (success %0d, failure %0d, fresh %0d, last %0d, due %0d),",
                 requests_sent, sent_by_type[REQ_SUCCESS], sent_by_type[REQ_FAILURE],
                 sent_by_type[REQ_FRESH], sent_by_type[REQ_LAST], sent_by_type[REQ_DUE]);
        $display("%0d results, %0d register settings, %0d long output holds, %0d mismatches",
                 results_checked, setting_changes, long_holds, error_count);
        if (error_count == 0)
            $display("peer_range_table_test: done, clean");
        else
            $display("peer_range_table_test: done, errors");
        $finish;
    end

endmodule
